### design/ahhd_pkg.sv
// shared constants, types and command/status structs for the average hash block
// no dependencies
`timescale 1ns / 1ps

package ahhd_pkg;

  localparam int TILE_PIXELS     = 64;
  localparam int ADDR_W          = $clog2(TILE_PIXELS);
  localparam int PIX_W           = 8;
  localparam int QUANT_SHIFT     = 2;
  localparam int STORE_W         = PIX_W - QUANT_SHIFT;
  localparam int SUM_W           = $clog2(((1 << PIX_W) - 1) * TILE_PIXELS + 1);
  localparam int CNT_W           = $clog2(TILE_PIXELS + 1);
  localparam int DIST_W          = 7;
  localparam int ABSENT_DISTANCE = 40;
  localparam int DISTANCE_MAX    = (1 << DIST_W) - 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TILE_PIXELS - 1);

  typedef struct packed {
    logic load;
    logic absent;
    logic scan_rd;
    logic finish;
  } ahhd_cmd_t;

  typedef struct packed {
    logic last_pixel;
    logic scan_last;
  } ahhd_status_t;

endpackage

### design/ahhd_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ahhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ahhd_datapath.sv
// datapath: tile store, running sums, compare pass counter and result registers
// depends on ahhd_pkg and ahhd_ram
`timescale 1ns / 1ps

module ahhd_datapath
  import ahhd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ahhd_cmd_t           cmd,
  output ahhd_status_t        status,
  input  logic [PIX_W-1:0]    pixel_a,
  input  logic [PIX_W-1:0]    pixel_b,
  output logic                done,
  output logic [DIST_W-1:0]   distance,
  output logic                no_image
);

  localparam logic [SUM_W-1:0] TILE_DIV = SUM_W'(TILE_PIXELS);
  localparam int SAT_W = CNT_W + DIST_W;

  logic [SUM_W-1:0]     sum_a;
  logic [SUM_W-1:0]     sum_b;
  logic [ADDR_W-1:0]    pixel_count;
  logic [ADDR_W-1:0]    scan_addr;
  logic                 cmp_valid;
  logic [CNT_W-1:0]     acc;

  logic [STORE_W-1:0]   q_a;
  logic [STORE_W-1:0]   q_b;
  logic [2*STORE_W-1:0] rd_data;
  logic [PIX_W-1:0]     avg_a;
  logic [PIX_W-1:0]     avg_b;
  logic [PIX_W-1:0]     rd_qa;
  logic [PIX_W-1:0]     rd_qb;
  logic                 diff;
  logic [CNT_W-1:0]     acc_next;
  logic                 saturate;

  assign q_a = pixel_a[PIX_W-1:QUANT_SHIFT];
  assign q_b = pixel_b[PIX_W-1:QUANT_SHIFT];

  // both tiles share one ram word per position
  ahhd_ram #(
    .WIDTH (2 * STORE_W),
    .DEPTH (TILE_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (pixel_count),
    .wdata ({q_a, q_b}),
    .raddr (scan_addr),
    .rdata (rd_data)
  );

  // sums hold still through the pass, so averages are plain shifts of them
  assign avg_a = PIX_W'(sum_a / TILE_DIV);
  assign avg_b = PIX_W'(sum_b / TILE_DIV);

  assign rd_qa = {rd_data[2*STORE_W-1:STORE_W], {QUANT_SHIFT{1'b0}}};
  assign rd_qb = {rd_data[STORE_W-1:0], {QUANT_SHIFT{1'b0}}};
  assign diff  = (rd_qa >= avg_a) != (rd_qb >= avg_b);

  assign acc_next = (cmp_valid && diff) ? acc + CNT_W'(1) : acc;
  assign saturate = SAT_W'(acc_next) > SAT_W'(DISTANCE_MAX);

  assign status.last_pixel = pixel_count == LAST_ADDR;
  assign status.scan_last  = scan_addr == LAST_ADDR;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a       <= '0;
      sum_b       <= '0;
      pixel_count <= '0;
      scan_addr   <= '0;
      cmp_valid   <= 1'b0;
      acc         <= '0;
      done        <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_rd;
      done      <= cmd.absent || cmd.finish;

      if (cmd.absent || cmd.finish) begin
        sum_a       <= '0;
        sum_b       <= '0;
        pixel_count <= '0;
        scan_addr   <= '0;
        acc         <= '0;
      end else begin
        if (cmd.load) begin
          sum_a       <= sum_a + SUM_W'({q_a, {QUANT_SHIFT{1'b0}}});
          sum_b       <= sum_b + SUM_W'({q_b, {QUANT_SHIFT{1'b0}}});
          pixel_count <= pixel_count + ADDR_W'(1);
        end
        if (cmd.scan_rd) begin
          scan_addr <= scan_addr + ADDR_W'(1);
        end
        acc <= acc_next;
      end
    end
  end

  // result word, payload only
  always_ff @(posedge clk) begin
    if (cmd.absent) begin
      distance <= DIST_W'(ABSENT_DISTANCE);
      no_image <= 1'b1;
    end else if (cmd.finish) begin
      distance <= saturate ? DIST_W'(DISTANCE_MAX) : DIST_W'(acc_next);
      no_image <= 1'b0;
    end
  end

  a_absent_word: assert property (@(posedge clk) disable iff (rst)
    cmd.absent |=> done && no_image && distance == DIST_W'(ABSENT_DISTANCE))
    else $error("absent word not emitted as expected");

  a_finish_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> cmp_valid)
    else $error("finish without the last store read in flight");

  a_load_not_in_scan: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && (cmd.scan_rd || cmd.finish)))
    else $error("load overlaps the compare pass");

endmodule

### design/ahhd_ctrl.sv
// controller state machine: accepts words, sequences the compare pass
// depends on ahhd_pkg
`timescale 1ns / 1ps

module ahhd_ctrl
  import ahhd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         image_absent,
  input  ahhd_status_t status,
  output ahhd_cmd_t    cmd,
  output logic         busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.absent  = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (image_absent) begin
            cmd.absent = 1'b1;
          end else begin
            cmd.load = 1'b1;
            if (status.last_pixel) begin
              state_next = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last store read lands here
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_tile_end_scans: assert property (@(posedge clk) disable iff (rst)
    accept && !image_absent && status.last_pixel |=> state == ST_SCAN)
    else $error("tile end did not start the compare pass");

  a_scan_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && !status.scan_last |=> state == ST_SCAN)
    else $error("compare pass left early");

  a_drain_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |=> state == ST_IDLE && !busy)
    else $error("drain did not return to idle");

endmodule

### design/average_hash_hamming_distance.sv
// top level of the average hash hamming distance block
// depends on ahhd_pkg, ahhd_ctrl, ahhd_datapath (and ahhd_ram below it)
`timescale 1ns / 1ps

// Takes one pixel pair a word while busy is low and start is high, in raster
// order over a tile of TILE_PIXELS pixels. The word that completes a tile
// starts a compare pass that reads the tile store one position a cycle and
// holds busy high through the pass and a final drain step; the single read
// port of the store sets the length of that pass. A word with image_absent
// set restarts the tile and yields distance 40 with no_image high. Each result
// appears on distance/no_image for exactly one cycle with done high; done is
// registered and comes in the cycle after the absent word or the drain step;
// there is no back-pressure, so the receiver must take it in that cycle.

module average_hash_hamming_distance
  import ahhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [PIX_W-1:0]  pixel_a,
  input  logic [PIX_W-1:0]  pixel_b,
  input  logic              image_absent,
  output logic              done,
  output logic [DIST_W-1:0] distance,
  output logic              no_image
);

  ahhd_cmd_t    cmd;
  ahhd_status_t status;

  ahhd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .image_absent (image_absent),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  ahhd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .pixel_a  (pixel_a),
    .pixel_b  (pixel_b),
    .done     (done),
    .distance (distance),
    .no_image (no_image)
  );

endmodule
